// ===== rtl/dul_pkg.sv =====
// Package for the dot-unstuffing line deframer: types, character codes,
// register indexes and the per-byte line helper. No dependencies.
package dul_pkg;

  localparam int LENGTH_BITS = 16;
  // Line counter width: saturation value never exceeds 16 bits
  localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  localparam int LEN_W = 16;

  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t LEN_MAX = '1;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Configuration register indexes
  localparam logic CFG_DATA_MODE = 1'b0;
  localparam logic CFG_STRIP_CR  = 1'b1;

  typedef enum logic [2:0] {
    PH_SOL,
    PH_DOT,
    PH_DOTCR,
    PH_IN,
    PH_END
  } phase_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             line_end;
    logic [LEN_W-1:0] line_length;
    logic             end_of_data;
    logic             last;
  } result_t;

  // Results of one byte, compacted: r0 first, num valid entries
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } step_res_t;

  // One ordinary byte: optional result and the updated line count
  typedef struct packed {
    logic    emit;
    result_t res;
    cnt_t    count;
  } plain_t;

  function automatic plain_t plain_byte(input logic [7:0] c, input logic strip,
                                        input cnt_t count);
    plain_t p;
    p = '0;
    if (c == CH_LF) begin
      p.emit             = 1'b1;
      p.res.out_byte     = CH_LF;
      p.res.has_byte     = 1'b1;
      p.res.line_end     = 1'b1;
      p.res.line_length  = LEN_W'(count);
      p.count            = '0;
    end else if (c == CH_CR && strip) begin
      p.count = count;
    end else begin
      p.emit         = 1'b1;
      p.res.out_byte = c;
      p.res.has_byte = 1'b1;
      p.count        = (count != LEN_MAX) ? count + 1'b1 : count;
    end
    return p;
  endfunction

  function automatic phase_t plain_phase(input logic [7:0] c);
    return (c == CH_LF) ? PH_SOL : PH_IN;
  endfunction

endpackage

// ===== rtl/dul_step.sv =====
// Per-byte parse logic: results and next parse state for one received byte.
// Depends on dul_pkg.
module dul_step (
  input  logic [7:0]         rx_byte,
  input  logic               data_mode,
  input  logic               strip_cr,
  input  dul_pkg::phase_t    phase,
  input  dul_pkg::cnt_t      count,
  output dul_pkg::step_res_t res,
  output dul_pkg::phase_t    phase_next,
  output dul_pkg::cnt_t      count_next
);

  dul_pkg::plain_t p1;   // byte taken as ordinary
  dul_pkg::plain_t pc;   // held CR released
  dul_pkg::plain_t p2;   // byte following the released CR
  dul_pkg::result_t ra;
  dul_pkg::result_t rb;
  logic ea;
  logic eb;

  assign p1 = dul_pkg::plain_byte(rx_byte, strip_cr, count);
  assign pc = dul_pkg::plain_byte(dul_pkg::CH_CR, strip_cr, count);
  assign p2 = dul_pkg::plain_byte(rx_byte, strip_cr, pc.count);

  // next state
  always_comb begin
    phase_next = phase;
    count_next = count;
    priority if (phase == dul_pkg::PH_END) begin
      phase_next = phase;
    end else if (!data_mode) begin
      phase_next = dul_pkg::plain_phase(rx_byte);
      count_next = p1.count;
    end else begin
      unique case (phase)
        dul_pkg::PH_SOL: begin
          if (rx_byte == dul_pkg::CH_DOT) begin
            phase_next = dul_pkg::PH_DOT;
          end else begin
            phase_next = dul_pkg::plain_phase(rx_byte);
            count_next = p1.count;
          end
        end
        dul_pkg::PH_DOT: begin
          if (rx_byte == dul_pkg::CH_CR) begin
            phase_next = dul_pkg::PH_DOTCR;
          end else begin
            phase_next = dul_pkg::plain_phase(rx_byte);
            count_next = p1.count;
          end
        end
        dul_pkg::PH_DOTCR: begin
          if (rx_byte == dul_pkg::CH_LF) begin
            phase_next = dul_pkg::PH_END;
            count_next = '0;
          end else begin
            phase_next = dul_pkg::plain_phase(rx_byte);
            count_next = p2.count;
          end
        end
        dul_pkg::PH_IN: begin
          phase_next = dul_pkg::plain_phase(rx_byte);
          count_next = p1.count;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // raw results, before compaction
  always_comb begin
    ea = 1'b0;
    eb = 1'b0;
    ra = '0;
    rb = '0;
    priority if (phase == dul_pkg::PH_END) begin
      ea = 1'b0;
    end else if (data_mode && phase == dul_pkg::PH_DOTCR) begin
      if (rx_byte == dul_pkg::CH_LF) begin
        ea             = 1'b1;
        ra.end_of_data = 1'b1;
      end else begin
        ea = pc.emit;
        ra = pc.res;
        eb = p2.emit;
        rb = p2.res;
      end
    end else if (data_mode && (phase == dul_pkg::PH_SOL && rx_byte == dul_pkg::CH_DOT ||
                               phase == dul_pkg::PH_DOT && rx_byte == dul_pkg::CH_CR)) begin
      ea = 1'b0;
    end else begin
      ea = p1.emit;
      ra = p1.res;
    end
  end

  // compact and mark the final result of the byte
  always_comb begin
    res = '0;
    if (ea) begin
      res.r0  = ra;
      res.r1  = rb;
      res.num = eb ? 2'd2 : 2'd1;
    end else begin
      res.r0  = rb;
      res.num = eb ? 2'd1 : 2'd0;
    end
    if (res.num == 2'd2) begin
      res.r1.last = 1'b1;
    end else if (res.num == 2'd1) begin
      res.r0.last = 1'b1;
    end
  end

endmodule

// ===== rtl/dul_outq.sv =====
// Two-slot result queue: takes up to two results a cycle, shows one.
// Depends on dul_pkg.
module dul_outq (
  input  logic               clk,
  input  logic               rst,
  input  dul_pkg::step_res_t push,   // push.num already gated by caller
  input  logic               out_ready,
  output logic               out_valid,
  output dul_pkg::result_t   head,
  output logic [1:0]         room
);

  dul_pkg::result_t s0;
  dul_pkg::result_t s1;
  logic [1:0] count;
  logic [1:0] keep;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign keep      = count - {1'b0, pop};
  assign room      = 2'd2 - keep;
  assign out_valid = (count != 2'd0);
  assign head      = s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= keep + push.num;
    end
  end

  always_ff @(posedge clk) begin
    unique case (keep)
      2'd0: begin
        s0 <= push.r0;
        s1 <= push.r1;
      end
      2'd1: begin
        if (pop) begin
          s0 <= s1;
        end
        s1 <= push.r0;
      end
      default: begin
        s0 <= s0;
        s1 <= s1;
      end
    endcase
  end

endmodule

// ===== rtl/dot_unstuff_line_deframer_unit.sv =====
// Dot-unstuffing line deframer, top level: input register, parse state,
// per-byte logic and result queue. Depends on dul_pkg, dul_step, dul_outq.
//
// Takes one received byte per transfer and delivers zero, one or two results
// per byte. One byte can be accepted every clock; a byte whose results wait
// in the two-slot output queue does not hold off the next byte unless the
// queue lacks room for that byte's results. A byte's first result is shown
// after the input register and then the queue register. Bytes that release a
// held CR next to an ordinary byte produce two results and so use two output
// transfers; this output port bandwidth is what limits the rate.
// In data mode a leading dot is removed and a dot CR LF line gives one
// end-of-data result, after which all bytes are dropped until data_mode is
// written again. Any data_mode write returns to start of line with a cleared
// line count. The user must write configuration only while the block is idle;
// the block does not check. No memories, no clearing pass: ready after reset.
module dot_unstuff_line_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // received byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] out_byte, [23:8] line_length
  output logic [2:0]  m_tuser,    // [0] has_byte, [1] line_end, [2] end_of_data
  output logic        m_tlast,    // final result of the input byte
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,  // 0 data_mode, 1 strip_cr
  input  logic        cfg_wdata
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parse state and configuration
  logic            data_mode;
  logic            strip_cr;
  dul_pkg::phase_t phase;
  dul_pkg::phase_t phase_next;
  dul_pkg::cnt_t   line_count;
  dul_pkg::cnt_t   line_count_next;

  dul_pkg::step_res_t step_res;
  dul_pkg::step_res_t push;
  dul_pkg::result_t   head;
  logic [1:0]         room;
  logic               proceed;

  dul_step u_step (
    .rx_byte    (in_byte),
    .data_mode  (data_mode),
    .strip_cr   (strip_cr),
    .phase      (phase),
    .count      (line_count),
    .res        (step_res),
    .phase_next (phase_next),
    .count_next (line_count_next)
  );

  // The registered byte is processed once the queue can hold all its results.
  assign proceed  = in_valid && (step_res.num <= room);
  assign s_tready = !in_valid || proceed;

  always_comb begin
    push = step_res;
    if (!proceed) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proceed) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // state update; the user must write config only while idle, unchecked here
  always_ff @(posedge clk) begin
    if (rst) begin
      data_mode  <= 1'b0;
      strip_cr   <= 1'b1;
      phase      <= dul_pkg::PH_SOL;
      line_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dul_pkg::CFG_DATA_MODE: begin
          data_mode  <= cfg_wdata;
          phase      <= dul_pkg::PH_SOL;
          line_count <= '0;
        end
        dul_pkg::CFG_STRIP_CR: begin
          strip_cr <= cfg_wdata;
        end
      endcase
    end else if (proceed) begin
      phase      <= phase_next;
      line_count <= line_count_next;
    end
  end

  dul_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .head      (head),
    .room      (room)
  );

  assign m_tdata = {head.line_length, head.out_byte};
  assign m_tuser = {head.end_of_data, head.line_end, head.has_byte};
  assign m_tlast = head.last;

endmodule

// ===== rtl/dul_checker.sv =====
// Port-level checks for the deframer top level, attached by bind.
// Depends on dul_pkg and dot_unstuff_line_deframer_unit.
module dul_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // end-of-data result carries no byte and closes the input byte
  a_eod: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'b00 && m_tdata == 24'd0 && m_tlast)
    else $error("malformed end-of-data result");

  // line end is always a delivered LF
  a_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[7:0] == dul_pkg::CH_LF)
    else $error("line end without LF byte");

  // length only reported on line end
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[23:8] == 16'd0)
    else $error("line length outside line end");

endmodule

bind dot_unstuff_line_deframer_unit dul_checker u_dul_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== test/dot_unstuff_line_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dot_unstuff_line_deframer_unit: a scoreboard class that
// predicts the deframed results, plus driver tasks. Depends on dul_pkg and the RTL.

module dot_unstuff_line_deframer_unit_tb;

  localparam int          STALL_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int          HOLD_CYCLES = 400;   // long receiver hold-off for back-pressure
  localparam int          SETTLE      = 8;     // covers bytes in flight that give no result
  localparam int          RAND_ITEMS  = 1400;
  localparam logic [15:0] LINE_CAP    = (dul_pkg::LENGTH_BITS >= 16) ? 16'hFFFF
                                        : 16'((1 << dul_pkg::LENGTH_BITS) - 1);

  // Deframer prediction and result checking.
  class deframer_scoreboard;
    bit               data_mode;
    bit               strip_cr;
    dul_pkg::phase_t  phase;
    logic [15:0]      line_cnt;
    dul_pkg::result_t expected_q[$];
    int unsigned      errors;
    int unsigned      bytes_used;  // bytes not swallowed by the ended phase

    function new();
      data_mode = 1'b0;
      strip_cr  = 1'b1;
      phase     = dul_pkg::PH_SOL;
      line_cnt  = '0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == dul_pkg::CFG_DATA_MODE) begin
        data_mode = val;
        phase     = dul_pkg::PH_SOL;
        line_cnt  = '0;
      end else begin
        strip_cr = val;
      end
    endfunction

    // Byte with no dot handling: LF closes the line, CR may be dropped
    function void ordinary(logic [7:0] c);
      dul_pkg::result_t r;
      r = '0;
      if (c == dul_pkg::CH_LF) begin
        r.out_byte    = dul_pkg::CH_LF;
        r.has_byte    = 1'b1;
        r.line_end    = 1'b1;
        r.line_length = line_cnt;
        expected_q.push_back(r);
        line_cnt = '0;
        phase    = dul_pkg::PH_SOL;
      end else begin
        phase = dul_pkg::PH_IN;
        if (!(c == dul_pkg::CH_CR && strip_cr)) begin
          r.out_byte = c;
          r.has_byte = 1'b1;
          expected_q.push_back(r);
          if (line_cnt != LINE_CAP) line_cnt++;
        end
      end
    endfunction

    function void take_byte(logic [7:0] c);
      int               n_prior;
      dul_pkg::result_t r;
      n_prior = expected_q.size();
      if (phase == dul_pkg::PH_END) return;
      bytes_used++;
      if (!data_mode) begin
        ordinary(c);
      end else begin
        unique case (phase)
          dul_pkg::PH_SOL: begin
            if (c == dul_pkg::CH_DOT) phase = dul_pkg::PH_DOT;
            else ordinary(c);
          end
          dul_pkg::PH_DOT: begin
            if (c == dul_pkg::CH_CR) phase = dul_pkg::PH_DOTCR;
            else ordinary(c);
          end
          dul_pkg::PH_DOTCR: begin
            if (c == dul_pkg::CH_LF) begin
              r = '0;
              r.end_of_data = 1'b1;
              expected_q.push_back(r);
              phase    = dul_pkg::PH_END;
              line_cnt = '0;
            end else begin
              // held CR is released first, then the byte itself
              ordinary(dul_pkg::CH_CR);
              ordinary(c);
            end
          end
          default: ordinary(c);
        endcase
      end
      if (expected_q.size() > n_prior) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [23:0] data, logic [2:0] user, logic lst);
      dul_pkg::result_t got;
      dul_pkg::result_t want;
      got.out_byte    = data[7:0];
      got.line_length = data[23:8];
      got.has_byte    = user[0];
      got.line_end    = user[1];
      got.end_of_data = user[2];
      got.last        = lst;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte=%02h has=%0d le=%0d len=%0d eod=%0d last=%0d",
                   got.out_byte, got.has_byte, got.line_end, got.line_length,
                   got.end_of_data, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
          got.line_end !== want.line_end || got.line_length !== want.line_length ||
          got.end_of_data !== want.end_of_data || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: expected byte=%02h has=%0d le=%0d len=%0d eod=%0d last=%0d",
                   $realtime, want.out_byte, want.has_byte, want.line_end,
                   want.line_length, want.end_of_data, want.last);
          $display("  got byte=%02h has=%0d le=%0d len=%0d eod=%0d last=%0d",
                   got.out_byte, got.has_byte, got.line_end, got.line_length,
                   got.end_of_data, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_wdata;

  deframer_scoreboard sb = new();

  bit hold_on;   // sender asks the receiver for one long hold-off
  bit calm;      // final stretch: no idling on either side
  int stuck_cycles;

  dot_unstuff_line_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transfer monitor: at the edge, all signals still hold their pre-edge values,
  // so the sampled handshakes are the ones the block sees.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request,
  // always ready in the calm stretch.
  initial begin
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_on) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and wait for its transfer; a random idle burst may come first.
  task automatic send_byte(logic [7:0] b);
    if (!calm && !hold_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering, wait for every expected result, then let in-flight bytes
  // that produce nothing drain through the pipeline.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Line content: biased toward dots and CRs, otherwise any byte value
  function automatic logic [7:0] text_byte();
    unique case ($urandom_range(0, 9))
      0:       return dul_pkg::CH_CR;
      1:       return dul_pkg::CH_DOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One line: plain, dot-stuffed, empty dot line, or dot CR with a held CR,
  // ended by CR LF, bare LF, or now and then left open.
  task automatic send_line();
    int kind;
    int tail;
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      send_byte(dul_pkg::CH_DOT);
      send_byte(dul_pkg::CH_LF);
      return;
    end
    if (kind == 5 || kind == 6) begin
      send_byte(dul_pkg::CH_DOT);
    end else if (kind == 8) begin
      send_byte(dul_pkg::CH_DOT);
      send_byte(dul_pkg::CH_CR);
    end else if (kind == 9) begin
      send_byte(dul_pkg::CH_DOT);
      send_byte(dul_pkg::CH_CR);
      send_byte(dul_pkg::CH_CR);
    end
    repeat ($urandom_range(0, 12)) send_byte(text_byte());
    tail = $urandom_range(0, 19);
    if (tail < 14) begin
      send_byte(dul_pkg::CH_CR);
      send_byte(dul_pkg::CH_LF);
    end else if (tail < 19) begin
      send_byte(dul_pkg::CH_LF);
    end
  endtask

  initial begin
    int          blk;
    int unsigned start_used;
    bit          dm;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = dul_pkg::CFG_DATA_MODE;
    cfg_wdata = 1'b0;
    hold_on   = 1'b0;
    calm      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Line mode after reset, CRs dropped: byte extremes, dot passes through
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dul_pkg::CH_CR);
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_LF);

    // Line mode keeping CRs
    wait_quiet();
    write_cfg(dul_pkg::CFG_STRIP_CR, 1'b1 ^ 1'b1);
    send_byte("A");
    send_byte(dul_pkg::CH_CR);
    send_byte(dul_pkg::CH_LF);

    // Data mode: dot-stuffed dot, empty dot line, held CR released with next byte
    wait_quiet();
    write_cfg(dul_pkg::CFG_DATA_MODE, 1'b1);
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_LF);
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_LF);
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_CR);
    send_byte("x");
    send_byte(dul_pkg::CH_LF);

    // strip_cr flipped while a CR is held: the new value decides its fate
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_CR);
    wait_quiet();
    write_cfg(dul_pkg::CFG_STRIP_CR, 1'b1);
    send_byte("y");
    send_byte(dul_pkg::CH_LF);

    // Terminator line, then a byte that must be dropped
    send_byte(dul_pkg::CH_DOT);
    send_byte(dul_pkg::CH_CR);
    send_byte(dul_pkg::CH_LF);
    send_byte("z");

    // Random blocks: mostly well-formed lines and data sections, some noise
    start_used = sb.bytes_used;
    blk = 0;
    while (sb.bytes_used - start_used < RAND_ITEMS) begin
      wait_quiet();
      if (sb.bytes_used - start_used > RAND_ITEMS - 250) calm = 1'b1;
      dm = 1'($urandom_range(0, 1));
      write_cfg(dul_pkg::CFG_DATA_MODE, dm);
      if ($urandom_range(0, 1)) write_cfg(dul_pkg::CFG_STRIP_CR, 1'($urandom_range(0, 1)));
      if (blk == 2 || blk == 9) begin
        // receiver holds off while bytes keep coming: fills the block and stalls input
        hold_on = 1'b1;
        repeat (24) send_byte(text_byte());
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 30)) send_byte(text_byte());
      end else if (dm) begin
        repeat ($urandom_range(1, 8)) send_line();
        if ($urandom_range(0, 3) != 0) begin
          send_byte(dul_pkg::CH_DOT);
          send_byte(dul_pkg::CH_CR);
          send_byte(dul_pkg::CH_LF);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(2, 10)) send_line();
      end
      blk++;
    end

    wait_quiet();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dul_pkg.sv
rtl/dul_step.sv
rtl/dul_outq.sv
rtl/dot_unstuff_line_deframer_unit.sv
rtl/dul_checker.sv
test/dot_unstuff_line_deframer_unit_tb.sv
